// File: hw/rtl/line_sensor_weighted_position_macros.svh
// Assertion helpers used by the checker of this block.
`ifndef LINE_SENSOR_WEIGHTED_POSITION_MACROS_SVH
`define LINE_SENSOR_WEIGHTED_POSITION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LSWP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define LSWP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/lswp_pkg.sv
`timescale 1ns / 1ps

package lswp_pkg;

    localparam int SAMPLE_BITS   = 10;
    localparam int FRACTION_BITS = 8;
    localparam int NUM_SENSORS   = 5;
    localparam int POS_BITS      = 12;
    localparam int COUNT_BITS    = 3;
    localparam int THRESH_BITS   = 10;
    localparam int CMP_BITS      = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;
    localparam int SUM_BITS      = SAMPLE_BITS + 3;
    localparam int MAG_BITS      = SAMPLE_BITS + 4;
    localparam int WSUM_BITS     = SAMPLE_BITS + 5;
    localparam int QUO_BITS      = FRACTION_BITS + 3;
    localparam int DVD_BITS      = MAG_BITS + FRACTION_BITS;
    localparam int EXT_BITS      = (QUO_BITS + 1 > POS_BITS) ? QUO_BITS + 1 : POS_BITS;
    localparam int ADDR_BITS     = 3;
    localparam int DATA_BITS     = 32;

    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_MIN_COUNT = 1'b1;

    localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET = THRESH_BITS'(600);
    localparam logic [COUNT_BITS-1:0]  MIN_COUNT_RESET = COUNT_BITS'(3);

    localparam logic signed [3:0] SENSOR_WEIGHT [NUM_SENSORS] =
        '{-4'sd6, -4'sd3, 4'sd0, 4'sd3, 4'sd6};

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_far_left;
        logic [SAMPLE_BITS-1:0] sample_left;
        logic [SAMPLE_BITS-1:0] sample_center;
        logic [SAMPLE_BITS-1:0] sample_right;
        logic [SAMPLE_BITS-1:0] sample_far_right;
    } t_in;

    typedef struct packed {
        logic signed [POS_BITS-1:0] position_fixed;
        logic                       line_lost;
        logic [COUNT_BITS-1:0]      dark_count;
        logic                       on_dark_surface;
    } t_out;

    typedef struct packed {
        logic                  neg;
        logic                  lost;
        logic [COUNT_BITS-1:0] count;
        logic                  on_dark;
    } t_side;

    typedef struct packed {
        logic [MAG_BITS-1:0] mag;
        logic [SUM_BITS-1:0] dsum;
        t_side               side;
    } t_div_in;

    typedef struct packed {
        logic [QUO_BITS-1:0] quo;
        t_side               side;
    } t_div_out;

    typedef struct packed {
        logic [SUM_BITS-1:0] rem;
        logic [QUO_BITS-1:0] qd;
        logic [SUM_BITS-1:0] div;
        t_side               side;
    } t_stage;

    function automatic t_stage lswp_div_step(input t_stage src);
        logic [SUM_BITS:0] sh;
        logic [SUM_BITS:0] diff;
        logic              ge;
        t_stage            res;
        sh   = {src.rem, src.qd[QUO_BITS-1]};
        diff = sh - {1'b0, src.div};
        ge   = (sh >= {1'b0, src.div});
        res.rem  = ge ? diff[SUM_BITS-1:0] : sh[SUM_BITS-1:0];
        res.qd   = {src.qd[QUO_BITS-2:0], ge};
        res.div  = src.div;
        res.side = src.side;
        return res;
    endfunction

endpackage

// File: hw/rtl/line_sensor_weighted_position.sv
`timescale 1ns / 1ps
// Line position from five reflectance samples, far left to far right.
// Input channel: i_in_valid / o_in_ready carry one t_in item (five samples).
// Output channel: o_out_valid / i_out_ready carry one t_out result per item:
//   position as signed fixed point (weights -6, -3, 0, 3, 6, FRACTION_BITS
//   fraction bits, truncated toward zero), line_lost, dark_count and
//   on_dark_surface.
// Pipeline: a register for threshold and sums, then the stages of the
//   restoring divider, one bit per stage, and a register for sign and output.
// Throughput: one item per cycle unless stalled; each stage holds one item
//   with its own valid bit, so bubbles close up when the receiver stalls.
// Stall: a held result stays on o_out_data; upstream stages keep filling
//   until the pipeline is full, then o_in_ready drops. Nothing is lost.
// Registers over the APB port: dark_threshold at 0x0, min_dark_count at 0x4.
// Write them only while no item is in flight.
// Reset: all stages empty, dark_threshold = 600, min_dark_count = 3.

module line_sensor_weighted_position (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  lswp_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output lswp_pkg::t_out                      o_out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lswp_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [lswp_pkg::DATA_BITS-1:0]      pwdata,
    output logic [lswp_pkg::DATA_BITS-1:0]      prdata,
    output logic                                pready
);

    logic [lswp_pkg::THRESH_BITS-1:0] r_threshold;
    logic [lswp_pkg::COUNT_BITS-1:0]  r_min_count;
    logic                             w_front_valid;
    logic                             w_front_ready;
    lswp_pkg::t_div_in                w_front_stage;
    logic                             w_div_valid;
    logic                             w_div_ready;
    lswp_pkg::t_div_out               w_div_res;
    logic                             r_out_valid;
    lswp_pkg::t_out                   r_out;
    lswp_pkg::t_out                   n_out;
    logic [lswp_pkg::EXT_BITS-1:0]    w_quo_ext;
    logic [lswp_pkg::EXT_BITS-1:0]    w_pos_ext;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= lswp_pkg::THRESHOLD_RESET;
            r_min_count <= lswp_pkg::MIN_COUNT_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                lswp_pkg::REG_THRESHOLD: r_threshold <= pwdata[lswp_pkg::THRESH_BITS-1:0];
                lswp_pkg::REG_MIN_COUNT: r_min_count <= pwdata[lswp_pkg::COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            lswp_pkg::REG_THRESHOLD: prdata = lswp_pkg::DATA_BITS'(r_threshold);
            lswp_pkg::REG_MIN_COUNT: prdata = lswp_pkg::DATA_BITS'(r_min_count);
            default:                 prdata = '0;
        endcase
    end

    lswp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_data      (i_in_data),
        .i_threshold (r_threshold),
        .i_min_count (r_min_count),
        .i_ready     (w_front_ready),
        .o_ready     (o_in_ready),
        .o_valid     (w_front_valid),
        .o_stage     (w_front_stage)
    );

    lswp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front_valid),
        .i_stage (w_front_stage),
        .i_ready (w_div_ready),
        .o_ready (w_front_ready),
        .o_valid (w_div_valid),
        .o_res   (w_div_res)
    );

    assign w_div_ready = !r_out_valid || i_out_ready;
    assign w_quo_ext   = {{(lswp_pkg::EXT_BITS - lswp_pkg::QUO_BITS){1'b0}}, w_div_res.quo};
    assign w_pos_ext   = w_div_res.side.neg ? (~w_quo_ext + lswp_pkg::EXT_BITS'(1))
                                            : w_quo_ext;

    always_comb begin
        n_out.position_fixed  = w_div_res.side.lost ? '0
                              : w_pos_ext[lswp_pkg::POS_BITS-1:0];
        n_out.line_lost       = w_div_res.side.lost;
        n_out.dark_count      = w_div_res.side.count;
        n_out.on_dark_surface = w_div_res.side.on_dark;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_div_ready) begin
            r_out_valid <= w_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_div_ready && w_div_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: hw/rtl/lswp_front.sv
`timescale 1ns / 1ps

module lswp_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  lswp_pkg::t_in                       i_data,
    input  logic [lswp_pkg::THRESH_BITS-1:0]    i_threshold,
    input  logic [lswp_pkg::COUNT_BITS-1:0]     i_min_count,
    input  logic                                i_ready,
    output logic                                o_ready,
    output logic                                o_valid,
    output lswp_pkg::t_div_in                   o_stage
);

    logic [lswp_pkg::SAMPLE_BITS-1:0] w_samp [lswp_pkg::NUM_SENSORS];
    logic                             r_valid;
    lswp_pkg::t_div_in                r_stage;
    lswp_pkg::t_div_in                n_stage;

    assign w_samp[0] = i_data.sample_far_left;
    assign w_samp[1] = i_data.sample_left;
    assign w_samp[2] = i_data.sample_center;
    assign w_samp[3] = i_data.sample_right;
    assign w_samp[4] = i_data.sample_far_right;

    always_comb begin
        logic signed [lswp_pkg::WSUM_BITS-1:0] wsum;
        logic [lswp_pkg::SUM_BITS-1:0]         dsum;
        logic [lswp_pkg::COUNT_BITS-1:0]       count;
        logic                                  dark;
        wsum  = '0;
        dsum  = '0;
        count = '0;
        for (int i = 0; i < lswp_pkg::NUM_SENSORS; i++) begin
            dark = (lswp_pkg::CMP_BITS'(w_samp[i]) > lswp_pkg::CMP_BITS'(i_threshold));
            if (dark) begin
                wsum  = wsum + lswp_pkg::WSUM_BITS'(signed'({1'b0, w_samp[i]}))
                             * lswp_pkg::WSUM_BITS'(lswp_pkg::SENSOR_WEIGHT[i]);
                dsum  = dsum + lswp_pkg::SUM_BITS'(w_samp[i]);
                count = count + lswp_pkg::COUNT_BITS'(1);
            end
        end
        n_stage.side.neg     = wsum[lswp_pkg::WSUM_BITS-1];
        n_stage.mag          = wsum[lswp_pkg::WSUM_BITS-1]
                             ? lswp_pkg::MAG_BITS'(-wsum) : lswp_pkg::MAG_BITS'(wsum);
        n_stage.dsum         = dsum;
        n_stage.side.count   = count;
        n_stage.side.lost    = (count == '0);
        n_stage.side.on_dark = (count >= i_min_count);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

// File: hw/rtl/lswp_div.sv
`timescale 1ns / 1ps

module lswp_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  lswp_pkg::t_div_in      i_stage,
    input  logic                   i_ready,
    output logic                   o_ready,
    output logic                   o_valid,
    output lswp_pkg::t_div_out     o_res
);

    logic [lswp_pkg::DVD_BITS-1:0] w_dvd;
    lswp_pkg::t_stage              w_init;
    lswp_pkg::t_stage              w_src       [lswp_pkg::QUO_BITS];
    logic                          w_src_valid [lswp_pkg::QUO_BITS];
    logic                          w_rdy       [lswp_pkg::QUO_BITS];
    lswp_pkg::t_stage              n_stage     [lswp_pkg::QUO_BITS];
    lswp_pkg::t_stage              r_stage     [lswp_pkg::QUO_BITS];
    logic                          r_valid     [lswp_pkg::QUO_BITS];

    assign w_dvd       = {i_stage.mag, {lswp_pkg::FRACTION_BITS{1'b0}}};
    assign w_init.rem  = lswp_pkg::SUM_BITS'(w_dvd[lswp_pkg::DVD_BITS-1:lswp_pkg::QUO_BITS]);
    assign w_init.qd   = w_dvd[lswp_pkg::QUO_BITS-1:0];
    assign w_init.div  = i_stage.dsum;
    assign w_init.side = i_stage.side;

    for (genvar k = 0; k < lswp_pkg::QUO_BITS; k++) begin : g_step
        if (k == 0) begin : g_head
            assign w_src[k]       = w_init;
            assign w_src_valid[k] = i_valid;
        end else begin : g_body
            assign w_src[k]       = r_stage[k-1];
            assign w_src_valid[k] = r_valid[k-1];
        end

        if (k == lswp_pkg::QUO_BITS - 1) begin : g_tail
            assign w_rdy[k] = !r_valid[k] || i_ready;
        end else begin : g_mid
            assign w_rdy[k] = !r_valid[k] || w_rdy[k+1];
        end

        assign n_stage[k] = lswp_pkg::lswp_div_step(w_src[k]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_valid[k] <= w_src_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k] && w_src_valid[k]) begin
                r_stage[k] <= n_stage[k];
            end
        end
    end

    assign o_ready    = w_rdy[0];
    assign o_valid    = r_valid[lswp_pkg::QUO_BITS-1];
    assign o_res.quo  = r_stage[lswp_pkg::QUO_BITS-1].qd;
    assign o_res.side = r_stage[lswp_pkg::QUO_BITS-1].side;

endmodule

// File: hw/rtl/lswp_checker.sv
`timescale 1ns / 1ps
`include "line_sensor_weighted_position_macros.svh"

module lswp_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           o_out_valid,
    input  logic           i_out_ready,
    input  lswp_pkg::t_out o_out_data
);

    `LSWP_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "stalled result changed")
    `LSWP_ASSERT_IMP(a_lost_zero, o_out_valid && o_out_data.line_lost, o_out_data.position_fixed == '0 && o_out_data.dark_count == '0, "line lost with nonzero position or count")
    `LSWP_ASSERT_IMP(a_count_range, o_out_valid, o_out_data.dark_count <= lswp_pkg::COUNT_BITS'(lswp_pkg::NUM_SENSORS) && (o_out_data.line_lost == (o_out_data.dark_count == '0)), "dark count out of range or inconsistent")

endmodule

bind line_sensor_weighted_position lswp_checker u_lswp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// File: sim/tb_line_sensor_weighted_position.sv
`timescale 1ns / 1ps

module tb_line_sensor_weighted_position;
    import lswp_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_GAP      = 17;
    localparam int SAMPLE_MAX   = 2 ** SAMPLE_BITS - 1;
    localparam int DRAIN_CYCLES = 3 * (FRACTION_BITS + 5);

    localparam logic [ADDR_BITS-1:0] ADDR_THRESHOLD = ADDR_BITS'({REG_THRESHOLD, 2'b00});
    localparam logic [ADDR_BITS-1:0] ADDR_MIN_COUNT = ADDR_BITS'({REG_MIN_COUNT, 2'b00});

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in                  i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out                 o_out_data;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [ADDR_BITS-1:0] paddr       = '0;
    logic [DATA_BITS-1:0] pwdata      = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    logic [THRESH_BITS-1:0] cfg_threshold = 10'd600;
    logic [COUNT_BITS-1:0]  cfg_min_count = 3'd3;

    t_out expected_results[$];
    int   errors      = 0;
    int   cycle_count = 0;
    int   in_gap_max  = MAX_GAP;
    int   out_gap_max = MAX_GAP;

    line_sensor_weighted_position u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic t_out predict_position(input t_in item);
        logic [NUM_SENSORS*SAMPLE_BITS-1:0] flat;
        logic [SAMPLE_BITS-1:0]             reading;
        int                                 wsum;
        int                                 dsum;
        int                                 mag;
        int                                 quo;
        int                                 pos;
        int                                 count;
        t_out                               res;
        flat  = item;
        wsum  = 0;
        dsum  = 0;
        count = 0;
        pos   = 0;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            reading = flat[(NUM_SENSORS-1-i)*SAMPLE_BITS +: SAMPLE_BITS];
            if (reading > cfg_threshold) begin
                wsum += 3 * (i - 2) * int'(reading);
                dsum += int'(reading);
                count++;
            end
        end
        if (count != 0) begin
            mag = (wsum < 0) ? -wsum : wsum;
            quo = (mag << FRACTION_BITS) / dsum;
            pos = (wsum < 0) ? -quo : quo;
        end
        res.position_fixed  = POS_BITS'(pos);
        res.line_lost       = (count == 0);
        res.dark_count      = COUNT_BITS'(count);
        res.on_dark_surface = (count >= int'(cfg_min_count));
        return res;
    endfunction

    function automatic t_in make_item(input int fl, input int l, input int c, input int r,
                                      input int fr);
        t_in item;
        item.sample_far_left  = SAMPLE_BITS'(fl);
        item.sample_left      = SAMPLE_BITS'(l);
        item.sample_center    = SAMPLE_BITS'(c);
        item.sample_right     = SAMPLE_BITS'(r);
        item.sample_far_right = SAMPLE_BITS'(fr);
        return item;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] draw_sample();
        int pick;
        int level;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            level = $urandom_range(0, SAMPLE_MAX);
        end else if (pick < 8) begin
            level = int'(cfg_threshold) + int'($urandom_range(0, 6)) - 3;
        end else if (pick == 8) begin
            level = 0;
        end else begin
            level = SAMPLE_MAX;
        end
        if (level < 0) level = 0;
        if (level > SAMPLE_MAX) level = SAMPLE_MAX;
        return SAMPLE_BITS'(level);
    endfunction

    task automatic send_samples(input t_in item);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        expected_results.push_back(predict_position(item));
    endtask

    task automatic wait_drained();
        if (i_in_valid) i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [ADDR_BITS-1:0] addr,
                                input logic [DATA_BITS-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic read_config(input logic [ADDR_BITS-1:0] addr,
                               output logic [DATA_BITS-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        value = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_config(input int threshold, input int min_count);
        logic [DATA_BITS-1:0] readback;
        wait_drained();
        write_config(ADDR_THRESHOLD, DATA_BITS'(threshold));
        write_config(ADDR_MIN_COUNT, DATA_BITS'(min_count));
        cfg_threshold = THRESH_BITS'(threshold);
        cfg_min_count = COUNT_BITS'(min_count);
        read_config(ADDR_THRESHOLD, readback);
        if (readback[THRESH_BITS-1:0] !== cfg_threshold) begin
            $display("%0t: dark_threshold readback expected %0d got %0d",
                     $time, cfg_threshold, readback);
            errors++;
        end
        read_config(ADDR_MIN_COUNT, readback);
        if (readback[COUNT_BITS-1:0] !== cfg_min_count) begin
            $display("%0t: min_dark_count readback expected %0d got %0d",
                     $time, cfg_min_count, readback);
            errors++;
        end
    endtask

    task automatic run_random(input int count);
        t_in item;
        for (int n = 0; n < count; n++) begin
            item.sample_far_left  = draw_sample();
            item.sample_left      = draw_sample();
            item.sample_center    = draw_sample();
            item.sample_right     = draw_sample();
            item.sample_far_right = draw_sample();
            send_samples(item);
        end
    endtask

    task automatic test_threshold_edges();
        send_samples(make_item(0, 0, 0, 0, 0));
        send_samples(make_item(1023, 1023, 1023, 1023, 1023));
        send_samples(make_item(600, 600, 600, 600, 600));
        send_samples(make_item(601, 601, 601, 601, 601));
        send_samples(make_item(1023, 0, 0, 0, 0));
        send_samples(make_item(0, 1023, 0, 0, 0));
        send_samples(make_item(0, 0, 1023, 0, 0));
        send_samples(make_item(0, 0, 0, 1023, 0));
        send_samples(make_item(0, 0, 0, 0, 1023));
        send_samples(make_item(1023, 1023, 0, 0, 601));
        send_samples(make_item(601, 700, 800, 900, 1000));
        send_samples(make_item(0, 0, 601, 1023, 1023));
        send_samples(make_item(700, 650, 0, 0, 0));
    endtask

    task automatic test_register_extremes();
        apply_config(0, 0);
        send_samples(make_item(0, 0, 0, 0, 0));
        send_samples(make_item(1, 0, 0, 0, 0));
        send_samples(make_item(0, 0, 0, 0, 1));
        apply_config(1023, 7);
        send_samples(make_item(1023, 1023, 1023, 1023, 1023));
        apply_config(600, 6);
        send_samples(make_item(1023, 1023, 1023, 1023, 1023));
        apply_config(600, 5);
        send_samples(make_item(1023, 1023, 1023, 1023, 1023));
        send_samples(make_item(1023, 1023, 1023, 1023, 600));
        apply_config(1022, 1);
        send_samples(make_item(1023, 0, 0, 0, 1022));
    endtask

    task automatic test_random_mixed();
        apply_config(600, 3);
        in_gap_max  = MAX_GAP;
        out_gap_max = MAX_GAP;
        run_random(200);
    endtask

    task automatic test_random_settings();
        for (int k = 0; k < 6; k++) begin
            case (k)
                0: apply_config(0, 0);
                1: apply_config(1023, 7);
                2: apply_config(1, 6);
                3: apply_config(1022, 5);
                default: apply_config($urandom_range(0, SAMPLE_MAX), $urandom_range(0, 7));
            endcase
            run_random(70);
        end
    endtask

    task automatic test_backpressure();
        apply_config($urandom_range(0, SAMPLE_MAX), $urandom_range(0, 7));
        in_gap_max  = 0;
        out_gap_max = MAX_GAP;
        run_random(100);
    endtask

    task automatic test_streaming();
        in_gap_max  = 0;
        out_gap_max = 0;
        run_random(100);
        in_gap_max  = MAX_GAP;
        out_gap_max = MAX_GAP;
    endtask

    task automatic test_pause_for_results();
        for (int k = 0; k < 5; k++) begin
            run_random(10);
            wait_drained();
        end
    endtask

    initial begin
        t_out exp_res;
        int   gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = $urandom_range(0, out_gap_max);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            if (expected_results.size() == 0) begin
                $display("%0t: result with no transfer pending, expected none got %p",
                         $time, o_out_data);
                errors++;
            end else begin
                exp_res = expected_results.pop_front();
                if (o_out_data.position_fixed !== exp_res.position_fixed) begin
                    $display("%0t: position_fixed expected %0d got %0d", $time,
                             exp_res.position_fixed, o_out_data.position_fixed);
                    errors++;
                end
                if (o_out_data.line_lost !== exp_res.line_lost) begin
                    $display("%0t: line_lost expected %0b got %0b", $time,
                             exp_res.line_lost, o_out_data.line_lost);
                    errors++;
                end
                if (o_out_data.dark_count !== exp_res.dark_count) begin
                    $display("%0t: dark_count expected %0d got %0d", $time,
                             exp_res.dark_count, o_out_data.dark_count);
                    errors++;
                end
                if (o_out_data.on_dark_surface !== exp_res.on_dark_surface) begin
                    $display("%0t: on_dark_surface expected %0b got %0b", $time,
                             exp_res.on_dark_surface, o_out_data.on_dark_surface);
                    errors++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_line_sensor_weighted_position: errors");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_threshold_edges();
        test_register_extremes();
        test_random_mixed();
        test_random_settings();
        test_backpressure();
        test_streaming();
        test_pause_for_results();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("tb_line_sensor_weighted_position: clean");
        end else begin
            $display("tb_line_sensor_weighted_position: errors");
        end
        $finish;
    end

endmodule
